// ----- rtl/utf8_word_boundary_tokenizer_unit_assert.svh -----
// Assertion macros used by the tokenizer event queue.
// Depends on a clock named clk and an active-low reset named arst_n in the
// module that uses them.
`ifndef UTF8_WORD_BOUNDARY_TOKENIZER_UNIT_ASSERT_SVH
`define UTF8_WORD_BOUNDARY_TOKENIZER_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define UWBT_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition in one cycle implies another in the next cycle.
`define UWBT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/uwbt_pkg.sv -----
// Package of the UTF-8 word boundary tokenizer: payload types, event class
// and byte classification helpers. Depends on nothing.
package uwbt_pkg;

	localparam int WIN_LEN     = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_W       = 24;
	localparam logic [OUT_W-1:0] OUT_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] word_start;
		logic [OUT_W-1:0] word_length;
		logic             run_last;
	} out_item_t;

	// One classified character, or the end-of-text marker.
	typedef struct packed {
		logic is_end;
		logic step_end;
		logic delim;
		logic digit;
		logic first12;
		logic letter;
		logic mb;
		logic mb_ok;
		logic dot;
	} ev_class_t;

	function automatic logic [2:0] char_len(input logic [7:0] b);
		logic [2:0] r;
		r = 3'd1;
		if (b >= 8'hC0 && b <= 8'hDF) r = 3'd2;
		else if (b >= 8'hE0 && b <= 8'hEF) r = 3'd3;
		else if (b >= 8'hF0 && b <= 8'hF7) r = 3'd4;
		else if (b >= 8'hF8 && b <= 8'hFB) r = 3'd5;
		else if (b == 8'hFC || b == 8'hFD) r = 3'd6;
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		logic [7:0] l;
		l = b | 8'h20;
		return !b[7] && l >= 8'h61 && l <= 8'h7A;
	endfunction

	// Punctuation that stays inside words in forward mode.
	function automatic logic keep_fwd(input logic [7:0] b);
		return b == 8'h3B || b == 8'h2E || b == 8'h3A || b == 8'h3F ||
			b == 8'h21 || b == 8'h29 || b == 8'h28;
	endfunction

endpackage

// ----- rtl/uwbt_front.sv -----
// Front part of the tokenizer: lookahead window, UTF-8 decode and character
// classification. Depends on uwbt_pkg.
module uwbt_front #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   mode,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  uwbt_pkg::in_item_t     in_data,
	input  logic                   q_full,
	output logic                   ev_push,
	output uwbt_pkg::ev_class_t    ev_cls,
	output logic [OFFSET_BITS-1:0] ev_pos
);
	import uwbt_pkg::*;

	typedef enum logic [1:0] {
		FS_RUN   = 2'b01,
		FS_DRAIN = 2'b10
	} front_state_t;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	front_state_t           state_q;
	logic [7:0]             win_q [WIN_LEN];
	logic [2:0]             fill_q;
	logic [2:0]             cont_q;
	logic [OFFSET_BITS-1:0] pos_q;

	logic [7:0]  win_w [WIN_LEN];
	logic [7:0]  hw [WIN_LEN];
	logic [2:0]  fill_w;
	logic [2:0]  avail;
	logic [2:0]  len;
	logic [2:0]  n;
	logic [7:0]  b;
	logic [7:0]  mask;
	logic [31:0] cp;
	logic        accept;
	logic        do_head;
	logic        lead;
	logic        nbsp;
	logic        dinv;
	logic        drain_end;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == FS_RUN) && !q_full;
	assign fill_w = fill_q + {2'b0, accept};

	always_comb begin
		for (int k = 0; k < WIN_LEN; k++) begin
			win_w[k] = (accept && fill_q == 3'(k)) ? in_data.text_byte : win_q[k];
		end
		if (state_q == FS_DRAIN) begin
			hw = win_q;
			avail = fill_q;
		end else begin
			hw = win_w;
			avail = 3'(WIN_LEN);
		end
		b = hw[0];
		len = char_len(b);
		n = (len < avail) ? len : avail;
		case (len)
			3'd2: mask = 8'h1F;
			3'd3: mask = 8'h0F;
			3'd4: mask = 8'h07;
			3'd5: mask = 8'h03;
			3'd6: mask = 8'h01;
			default: mask = 8'hFF;
		endcase
		cp = {24'b0, b & mask};
		for (int k = 1; k < WIN_LEN; k++) begin
			if (3'(k) < n) cp = {cp[25:0], hw[k][5:0]};
		end
		nbsp = avail == 3'(WIN_LEN) && hw[0] == 8'h26 && hw[1] == 8'h6E &&
			hw[2] == 8'h62 && hw[3] == 8'h73 && hw[4] == 8'h70 && hw[5] == 8'h3B;
		if (b <= 8'd32) dinv = 1'b1;
		else if (b[7]) begin
			if (cp == 32'd133) dinv = 1'b1;
			else if (cp >= 32'h1E00 && cp <= 32'h1EFF) dinv = 1'b0;
			else dinv = cp >= 32'h250;
		end else if (is_digit(b)) dinv = 1'b0;
		else if (b == 8'h26) dinv = nbsp;
		else if (b == 8'h3D || is_alpha(b)) dinv = 1'b0;
		else dinv = 1'b1;
	end

	assign lead = cont_q == 3'd0;
	assign do_head = (state_q == FS_RUN) ? (accept && !in_data.end_of_text &&
		fill_w == 3'(WIN_LEN)) : (fill_q != 3'd0 && !q_full);
	assign drain_end = (state_q == FS_DRAIN) && fill_q == 3'd0 && !q_full;

	always_comb begin
		ev_cls = '0;
		if (drain_end) begin
			ev_cls.is_end = 1'b1;
			ev_cls.step_end = 1'b1;
		end else begin
			ev_cls.step_end = state_q == FS_RUN;
			ev_cls.delim = dinv && !(mode && keep_fwd(b));
			ev_cls.digit = is_digit(b);
			ev_cls.first12 = b == 8'h31 || b == 8'h32;
			ev_cls.letter = is_alpha(b) || b == 8'h5F;
			ev_cls.mb = b[7];
			ev_cls.mb_ok = (cp >= 32'h1E00 && cp <= 32'h1EFF) || cp < 32'h22A;
			ev_cls.dot = b == 8'h2E;
		end
	end

	assign ev_push = (do_head && lead) || drain_end;
	assign ev_pos = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_RUN;
			fill_q <= '0;
			cont_q <= '0;
			pos_q <= '0;
			for (int k = 0; k < WIN_LEN; k++) win_q[k] <= '0;
		end else begin
			if (do_head) begin
				for (int k = 0; k < WIN_LEN - 1; k++) win_q[k] <= hw[k+1];
				win_q[WIN_LEN-1] <= '0;
				fill_q <= ((state_q == FS_DRAIN) ? fill_q : fill_w) - 3'd1;
				cont_q <= lead ? len - 3'd1 : cont_q - 3'd1;
				if (pos_q != POS_MAX) pos_q <= pos_q + 1'b1;
			end else if (accept) begin
				win_q <= win_w;
				fill_q <= fill_w;
			end
			if (accept && in_data.end_of_text) state_q <= FS_DRAIN;
			if (drain_end) begin
				state_q <= FS_RUN;
				pos_q <= '0;
				cont_q <= '0;
			end
		end
	end

endmodule

// ----- rtl/uwbt_queue.sv -----
// Short event queue between the front and back parts of the tokenizer.
// Depends on uwbt_pkg and the assertion macro header.
`include "utf8_word_boundary_tokenizer_unit_assert.svh"

module uwbt_queue #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  uwbt_pkg::ev_class_t    wr_cls,
	input  logic [OFFSET_BITS-1:0] wr_pos,
	output logic                   full,
	input  logic                   pop,
	output logic                   empty,
	output uwbt_pkg::ev_class_t    rd_cls,
	output logic [OFFSET_BITS-1:0] rd_pos
);
	import uwbt_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	ev_class_t              cls_q [QUEUE_DEPTH];
	logic [OFFSET_BITS-1:0] pos_q [QUEUE_DEPTH];
	logic [PW-1:0]          wr_ptr_q;
	logic [PW-1:0]          rd_ptr_q;
	logic [PW:0]            count_q;

	assign full = count_q == (PW+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign rd_cls = cls_q[rd_ptr_q];
	assign rd_pos = pos_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cls_q[wr_ptr_q] <= wr_cls;
			pos_q[wr_ptr_q] <= wr_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
		end
	end

	`UWBT_ASSERT_ALWAYS(a_no_overflow, !(push && full), "event queue overflow")
	`UWBT_ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "event queue underflow")
	`UWBT_ASSERT_ALWAYS(a_count_bound, count_q <= (PW+1)'(QUEUE_DEPTH), "queue count too big")
	`UWBT_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "bad count")

endmodule

// ----- rtl/uwbt_back.sv -----
// Back part of the tokenizer: word tracking, shape filter and result output.
// Depends on uwbt_pkg.
module uwbt_back #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   mode,
	input  logic                   ev_valid,
	input  uwbt_pkg::ev_class_t    ev_cls,
	input  logic [OFFSET_BITS-1:0] ev_pos,
	output logic                   ev_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output uwbt_pkg::out_item_t    out_data
);
	import uwbt_pkg::*;

	localparam int PW = (OFFSET_BITS > OUT_W) ? OFFSET_BITS : OUT_W;

	typedef enum logic [1:0] {
		PH_HEAD    = 2'd0,
		PH_LETTERS = 2'd1,
		PH_TAIL    = 2'd2,
		PH_REST    = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] hcnt;
		logic [2:0] mcnt;
		logic       first12;
		logic       tail;
		logic       reject;
		logic       dot;
	} filt_t;

	function automatic filt_t filter_char(input filt_t f, input ev_class_t c);
		filt_t r;
		logic  done;
		r = f;
		done = 1'b0;
		if (r.phase == PH_HEAD) begin
			if (c.digit) begin
				if (r.hcnt == 3'd0 && c.first12) r.first12 = 1'b1;
				if (r.hcnt < 3'd5) r.hcnt = r.hcnt + 3'd1;
				done = 1'b1;
			end else r.phase = PH_LETTERS;
		end
		if (!done && r.phase == PH_LETTERS) begin
			if (c.mb) begin
				if (!c.mb_ok) r.reject = 1'b1;
				else if (r.mcnt < 3'd4) r.mcnt = r.mcnt + 3'd1;
				done = 1'b1;
			end else if (c.letter) begin
				if (r.mcnt < 3'd4) r.mcnt = r.mcnt + 3'd1;
				done = 1'b1;
			end else r.phase = PH_TAIL;
		end
		if (!done && r.phase == PH_TAIL) begin
			if (c.digit) r.tail = 1'b1;
			else begin
				r.phase = PH_REST;
				if (c.dot) r.dot = 1'b1;
			end
			done = 1'b1;
		end
		if (!done) r.dot = 1'b0;
		return r;
	endfunction

	function automatic logic filter_ok(input filt_t f);
		logic h;
		logic m;
		h = f.hcnt != 3'd0;
		m = f.mcnt != 3'd0;
		if (f.reject) return 1'b0;
		if (f.phase == PH_REST) return !h && f.tail && f.dot;
		if (h && m && !f.tail) return f.hcnt <= 3'd2 && f.mcnt <= 3'd3;
		if (h && !m) return f.hcnt <= 3'd3 || (f.hcnt == 3'd4 && f.first12);
		if (h && m && f.tail) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [OUT_W-1:0] sat(input logic [OFFSET_BITS-1:0] v);
		logic [PW-1:0] w;
		w = PW'(v);
		return (w > PW'(OUT_MAX)) ? OUT_MAX : w[OUT_W-1:0];
	endfunction

	logic                   inside_q;
	logic [OFFSET_BITS-1:0] begin_q;
	filt_t                  filt_q;
	logic                   held_q;
	logic                   held_final_q;
	out_item_t              held_data_q;
	logic                   out_valid_q;
	out_item_t              out_data_q;

	logic      out_free;
	logic      r_ok;
	logic      closes;
	out_item_t r_item;
	filt_t     filt_n;
	logic      emit;
	out_item_t emit_data;

	assign out_free = !out_valid_q || out_ready;
	assign ev_pop = ev_valid && out_free && !held_final_q;
	assign closes = ev_cls.is_end || ev_cls.delim;

	always_comb begin
		r_ok = closes && inside_q && (mode || filter_ok(filt_q));
		r_item.word_start = sat(begin_q);
		r_item.word_length = sat(ev_pos - begin_q);
		r_item.run_last = 1'b0;
		filt_n = filter_char(inside_q ? filt_q : '0, ev_cls);
	end

	// A held word goes out once it is known whether another word follows it in the
	// same step; the last word of a step carries the run marker.
	always_comb begin
		emit = 1'b0;
		emit_data = held_data_q;
		if (held_final_q) begin
			emit = out_free;
			emit_data.run_last = 1'b1;
		end else if (ev_pop) begin
			if (held_q) begin
				emit = r_ok || ev_cls.step_end;
				emit_data.run_last = !r_ok;
			end else if (r_ok && ev_cls.step_end) begin
				emit = 1'b1;
				emit_data = r_item;
				emit_data.run_last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_pop && !closes) begin
			if (!inside_q) begin_q <= ev_pos;
			filt_q <= filt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			held_q <= 1'b0;
			held_final_q <= 1'b0;
			out_valid_q <= 1'b0;
			held_data_q <= '0;
			out_data_q <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				out_data_q <= emit_data;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (held_final_q && out_free) begin
				held_q <= 1'b0;
				held_final_q <= 1'b0;
			end else if (ev_pop) begin
				inside_q <= !closes;
				if (held_q) begin
					if (r_ok) begin
						held_data_q <= r_item;
						held_final_q <= ev_cls.step_end;
					end else if (ev_cls.step_end) begin
						held_q <= 1'b0;
					end
				end else if (r_ok && !ev_cls.step_end) begin
					held_q <= 1'b1;
					held_data_q <= r_item;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

// ----- rtl/utf8_word_boundary_tokenizer_unit.sv -----
// Top level of the UTF-8 word boundary tokenizer: mode register and the
// front, queue and back parts. Depends on uwbt_pkg, uwbt_front, uwbt_queue, uwbt_back.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_ready     in_data  (text_byte, end_of_text)
//   output    out_valid / out_ready   out_data (word_start, word_length, run_last)
//   config    cfg_we                  cfg_data (mode)
//
// One byte transfer per cycle is sustained while the event queue is not full. A byte
// that ends the text starts a drain of the six-byte window, one byte per cycle while
// the queue is not full, followed by one end marker: the input is held off until the
// marker is queued. The back part handles one queued event per cycle while the output
// is free, and holds off events while the second of two words from one event is sent.
// Reset clears the window, the position counters, the queue and the word state at once.
// A stall on the output fills the four-entry event queue before the input is held off.
module utf8_word_boundary_tokenizer_unit #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  uwbt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output uwbt_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_data
);
	import uwbt_pkg::*;

	// Mode: 0 selects inverted delimiters with the shape filter, 1 forward delimiters.
	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	// Events travel from the front part to the back part through the queue.
	logic                   q_full;
	logic                   q_empty;
	logic                   ev_push;
	logic                   ev_pop;
	ev_class_t              wr_cls;
	ev_class_t              rd_cls;
	logic [OFFSET_BITS-1:0] wr_pos;
	logic [OFFSET_BITS-1:0] rd_pos;

	uwbt_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.ev_push  (ev_push),
		.ev_cls   (wr_cls),
		.ev_pos   (wr_pos)
	);

	uwbt_queue #(.OFFSET_BITS(OFFSET_BITS)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.wr_cls (wr_cls),
		.wr_pos (wr_pos),
		.full   (q_full),
		.pop    (ev_pop),
		.empty  (q_empty),
		.rd_cls (rd_cls),
		.rd_pos (rd_pos)
	);

	// The back part closes words and applies the shape filter with the current mode.
	uwbt_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.ev_valid  (!q_empty),
		.ev_cls    (rd_cls),
		.ev_pos    (rd_pos),
		.ev_pop    (ev_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- dv/utf8_word_boundary_tokenizer_unit_tb.sv -----
// Testbench for utf8_word_boundary_tokenizer_unit: a queue-fed driver, a monitor and a
// byte-level predictor of the tokenizer that builds the list of expected words.
// Depends on uwbt_pkg and the tokenizer RTL.
`timescale 1ns / 100ps

module utf8_word_boundary_tokenizer_unit_tb;
	import uwbt_pkg::*;

	localparam int WINDOW = 6;
	localparam int POS_MAX = 24'hFFFFFF;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic MODE_INVERTED = 1'b0;
	localparam logic MODE_FORWARD = 1'b1;

	// Filter flag bits.
	localparam int FLAG_FIRST12 = 1;
	localparam int FLAG_TAIL = 2;
	localparam int FLAG_REJECT = 4;
	localparam int FLAG_DOT = 8;

	// Shape filter phases.
	localparam int PH_HEAD = 0;
	localparam int PH_LETTERS = 1;
	localparam int PH_TAIL = 2;
	localparam int PH_REST = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_data = 1'b0;

	utf8_word_boundary_tokenizer_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Bytes waiting to be sent and the words the tokenizer must report.
	in_item_t text_q[$];
	out_item_t word_q[$];
	bit failed = 0;
	bit no_idle = 0;
	bit hold_req = 0;
	bit hold_done = 0;
	int hold_cnt = 0;
	int gap_cnt = 0;
	int cycle_cnt = 0;

	// Predictor state, kept in step with the accepted byte transfers.
	logic [7:0] win[WINDOW];
	int win_fill = 0;
	int text_pos = 0;
	bit in_word = 0;
	int word_pos = 0;
	int cont_left = 0;
	int fphase = PH_HEAD;
	int head_digits = 0;
	int letters = 0;
	int fflags = 0;
	logic tok_mode = MODE_INVERTED;

	function automatic int seq_len(logic [7:0] b);
		if (b >= 8'hC0 && b <= 8'hDF) return 2;
		if (b >= 8'hE0 && b <= 8'hEF) return 3;
		if (b >= 8'hF0 && b <= 8'hF7) return 4;
		if (b >= 8'hF8 && b <= 8'hFB) return 5;
		if (b == 8'hFC || b == 8'hFD) return 6;
		return 1;
	endfunction

	function automatic bit digit_byte(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit letter_byte(logic [7:0] b);
		logic [7:0] l;
		l = b | 8'h20;
		return !b[7] && l >= "a" && l <= "z";
	endfunction

	// Code point of the character at the window head, from the bytes present.
	function automatic logic [31:0] head_code(int len, int avail);
		logic [31:0] v;
		v = {24'd0, win[0]};
		if (len < 2) return v;
		v = v & (32'h1F >> (len - 2));
		for (int k = 1; k < len && k < avail; k++)
			v = (v << 6) | {26'd0, win[k][5:0]};
		return v;
	endfunction

	function automatic bit nbsp_ahead(int avail);
		logic [7:0] pat[WINDOW];
		pat = '{"&", "n", "b", "s", "p", ";"};
		if (avail < WINDOW) return 0;
		for (int k = 0; k < WINDOW; k++)
			if (win[k] != pat[k]) return 0;
		return 1;
	endfunction

	function automatic bit breaks_word(logic [7:0] b, logic [31:0] c, int avail);
		bit d;
		if (b <= 8'd32) d = 1;
		else if (b[7]) d = (c == 32'd133) ? 1 :
			(c >= 32'h1E00 && c <= 32'h1EFF) ? 0 : (c >= 32'h250);
		else if (digit_byte(b) || b == "=" || letter_byte(b)) d = 0;
		else if (b == "&") d = nbsp_ahead(avail);
		else d = 1;
		// Forward mode keeps sentence punctuation and brackets inside words.
		if (d && tok_mode == MODE_FORWARD && (b == ";" || b == "." || b == ":" ||
				b == "?" || b == "!" || b == ")" || b == "("))
			d = 0;
		return d;
	endfunction

	function automatic void shape_char(logic [7:0] b, logic [31:0] c);
		if (fphase == PH_HEAD) begin
			if (digit_byte(b)) begin
				if (head_digits == 0 && (b == "1" || b == "2")) fflags |= FLAG_FIRST12;
				if (head_digits < 5) head_digits++;
				return;
			end
			fphase = PH_LETTERS;
		end
		if (fphase == PH_LETTERS) begin
			if (b[7]) begin
				if ((c >= 32'h1E00 && c <= 32'h1EFF) || c < 32'h22A) begin
					if (letters < 4) letters++;
				end else begin
					fflags |= FLAG_REJECT;
				end
				return;
			end
			if (letter_byte(b) || b == "_") begin
				if (letters < 4) letters++;
				return;
			end
			fphase = PH_TAIL;
		end
		if (fphase == PH_TAIL) begin
			if (digit_byte(b)) begin
				fflags |= FLAG_TAIL;
				return;
			end
			fphase = PH_REST;
			if (b == ".") fflags |= FLAG_DOT;
			return;
		end
		fflags &= ~FLAG_DOT;
	endfunction

	function automatic bit shape_ok();
		bit t;
		t = (fflags & FLAG_TAIL) != 0;
		if (fflags & FLAG_REJECT) return 0;
		if (fphase == PH_REST) return head_digits == 0 && t && (fflags & FLAG_DOT) != 0;
		if (head_digits != 0 && letters != 0 && !t) return head_digits <= 2 && letters <= 3;
		if (head_digits != 0 && letters == 0)
			return head_digits <= 3 || (head_digits == 4 && (fflags & FLAG_FIRST12) != 0);
		if (head_digits != 0 && letters != 0 && t) return 0;
		return 1;
	endfunction

	function automatic void end_word(int stop);
		out_item_t w;
		in_word = 0;
		if (tok_mode == MODE_INVERTED && !shape_ok()) return;
		w.word_start = word_pos[23:0];
		w.word_length = 24'(stop - word_pos);
		w.run_last = 1'b0;
		word_q.insert(word_q.size(), w);
	endfunction

	// Classify the window head (when it is a lead byte) and shift it out.
	function automatic void consume_head();
		int len;
		logic [31:0] c;
		if (cont_left > 0) begin
			cont_left--;
		end else begin
			len = seq_len(win[0]);
			c = head_code(len, win_fill);
			if (breaks_word(win[0], c, win_fill)) begin
				if (in_word) end_word(text_pos);
			end else begin
				if (!in_word) begin
					in_word = 1;
					word_pos = text_pos;
					fphase = PH_HEAD;
					head_digits = 0;
					letters = 0;
					fflags = 0;
				end
				shape_char(win[0], c);
			end
			cont_left = len - 1;
		end
		for (int k = 0; k < WINDOW - 1; k++) win[k] = win[k + 1];
		win[WINDOW - 1] = 8'd0;
		if (win_fill > 0) win_fill--;
		if (text_pos < POS_MAX) text_pos++;
	endfunction

	function automatic void predict_words(in_item_t it);
		int first;
		first = word_q.size();
		if (win_fill >= WINDOW) consume_head();
		win[win_fill] = it.text_byte;
		win_fill++;
		if (it.end_of_text) begin
			while (win_fill > 0) consume_head();
			if (in_word) end_word(text_pos);
			text_pos = 0;
			cont_left = 0;
			in_word = 0;
		end else if (win_fill >= WINDOW) begin
			consume_head();
		end
		// The last word caused by one byte carries the run marker.
		if (word_q.size() > first) word_q[$].run_last = 1'b1;
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// Driver: holds each byte until its transfer, then idles or offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				predict_words(in_data);
				void'(text_q.pop_front());
			end
			if (gap_cnt > 0) begin
				gap_cnt--;
				in_valid <= 1'b0;
			end else if (text_q.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= text_q[0];
				gap_cnt = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks every word transfer against the oldest expected word and
	// stalls the output at random, once for a long stretch.
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_w;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (word_q.size() == 0) begin
					$error("unexpected word start=%0d length=%0d",
						out_data.word_start, out_data.word_length);
					failed = 1;
				end else begin
					exp_w = word_q.pop_front();
					if (out_data.word_start !== exp_w.word_start) begin
						$error("word_start expected %0d actual %0d",
							exp_w.word_start, out_data.word_start);
						failed = 1;
					end
					if (out_data.word_length !== exp_w.word_length) begin
						$error("word_length expected %0d actual %0d",
							exp_w.word_length, out_data.word_length);
						failed = 1;
					end
					if (out_data.run_last !== exp_w.run_last) begin
						$error("run_last expected %0d actual %0d",
							exp_w.run_last, out_data.run_last);
						failed = 1;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_idle ? 1'b1 : (pick_gap() == 0);
			end
		end
	end

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic put_byte(logic [7:0] b, bit eot);
		in_item_t it;
		it.text_byte = b;
		it.end_of_text = eot;
		text_q.insert(text_q.size(), it);
	endtask

	task automatic put_text(string s, bit eot);
		for (int k = 0; k < s.len(); k++) put_byte(s[k], eot && k == s.len() - 1);
	endtask

	// A word shaped as head digits, letters, tail digits, an optional dot and an optional
	// equals sign, followed by some kind of break.
	task automatic put_word();
		int n;
		n = $urandom_range(0, 5);
		for (int k = 0; k < n; k++)
			put_byte(8'(k == 0 && $urandom_range(0, 1) ? "1" + $urandom_range(0, 1) :
				"0" + $urandom_range(0, 9)), 0);
		n = $urandom_range(0, 4);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0: begin put_byte(8'hC3, 0); put_byte(8'hA9, 0); end
				1: begin put_byte(8'hE1, 0); put_byte(8'hBA, 0); put_byte(8'h80, 0); end
				2: begin put_byte(8'hC8, 0); put_byte(8'hB0, 0); end
				3: put_byte("_", 0);
				default: put_byte(8'("a" + $urandom_range(0, 25) -
					($urandom_range(0, 1) * 32)), 0);
			endcase
		end
		n = $urandom_range(0, 2);
		for (int k = 0; k < n; k++) put_byte(8'("0" + $urandom_range(0, 9)), 0);
		if ($urandom_range(0, 3) == 0) put_byte(".", 0);
		if ($urandom_range(0, 7) == 0) put_byte("=", 0);
		case ($urandom_range(0, 9))
			0: put_text("&nbsp;", 0);
			1: begin put_byte(8'hC2, 0); put_byte(8'h85, 0); end
			2: begin put_byte(8'hC9, 0); put_byte(8'h90, 0); end
			3: put_byte(",", 0);
			4: put_byte("(", 0);
			5: put_byte(8'($urandom_range(0, 255)), 0);
			default: put_byte(" ", 0);
		endcase
	endtask

	task automatic put_random_text(int n);
		int start;
		start = text_q.size();
		while (text_q.size() - start < n) begin
			if ($urandom_range(0, 5) == 0) put_byte(8'($urandom_range(0, 255)), 0);
			else put_word();
			if ($urandom_range(0, 9) == 0) text_q[$].end_of_text = 1'b1;
		end
		text_q[$].end_of_text = 1'b1;
	endtask

	task automatic set_mode(logic m);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		tok_mode = m;
	endtask

	// Waits until every byte is sent and every word checked, then lets the
	// block settle, since a text may end with no word to report.
	task automatic drain();
		while (text_q.size() > 0 || in_valid || word_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		for (int k = 0; k < WINDOW; k++) win[k] = 8'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: filter shapes, entity space, multibyte breaks, cut and stray bytes.
		set_mode(MODE_INVERTED);
		put_text("Ab 19ab 123a 1999 3999 12345 ab12. a1b 1a2 x&nbsp;y", 1);
		put_byte(8'hC2, 0); put_byte(8'h85, 0); put_text("w", 0);
		put_byte(8'hC8, 0); put_byte(8'hB0, 0); put_byte(8'hC9, 0); put_byte(8'h90, 0);
		put_byte(8'hFF, 0); put_byte(8'h80, 0); put_text("q", 0);
		put_byte(8'hE1, 0); put_byte(8'hBA, 1);
		drain();
		set_mode(MODE_FORWARD);
		put_text("a;b.c:d?e!(f) g_h", 0);
		put_byte(8'h00, 0); put_text("z", 0);
		put_byte(8'hFC, 0); put_byte(8'h7F, 0); put_byte(8'hF8, 1);
		drain();

		// Random phases in both modes, one without idling, one under a long stall.
		set_mode(MODE_INVERTED);
		put_random_text(100);
		drain();
		set_mode(MODE_FORWARD);
		no_idle = 1;
		put_random_text(100);
		drain();
		no_idle = 0;
		set_mode(MODE_INVERTED);
		hold_req = 1;
		put_random_text(100);
		drain();
		set_mode(MODE_FORWARD);
		put_random_text(100);
		drain();

		if (!failed && word_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/uwbt_pkg.sv
rtl/uwbt_front.sv
rtl/uwbt_queue.sv
rtl/uwbt_back.sv
rtl/utf8_word_boundary_tokenizer_unit.sv
dv/utf8_word_boundary_tokenizer_unit_tb.sv
